// ===== rtl/rcn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_pkg: shared types and constants of the chromaticity normaliser
// Widths of the pixel fields, the divider operands and the stage record.
// ----------------------------------------------------------------------------
package rcn_pkg;

	localparam int unsigned CHAN_W         = 8;
	localparam int unsigned LUM_W          = 10;
	localparam int unsigned NUM_W          = 17;
	localparam int unsigned DEN_W          = 11;
	localparam int unsigned QUO_W          = 8;
	localparam int unsigned BITS_PER_STAGE = 2;
	localparam int unsigned DIV_STAGES     = QUO_W / BITS_PER_STAGE;
	localparam int unsigned LANES          = 3;
	localparam int unsigned SCALE          = 510;
	localparam int unsigned CMP_W          = DEN_W + QUO_W - 1;
	localparam int unsigned ADDR_W         = 3;

	localparam logic REG_LUM_THR = 1'b0;

	typedef struct packed {
		logic [LANES-1:0][NUM_W-1:0] rem;
		logic [LANES-1:0][QUO_W-1:0] quo;
		logic [DEN_W-1:0]            den;
	} rcn_div_t;

endpackage

// ===== rtl/rcn_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_cfg: register port
// Holds the luminance threshold, written and read over the APB port.
// ----------------------------------------------------------------------------
module rcn_cfg
	import rcn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [LUM_W-1:0]  lum_thr
);

	logic [LUM_W-1:0] lum_thr_q;

	assign pready  = 1'b1;
	assign lum_thr = lum_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lum_thr_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LUM_THR) begin
			lum_thr_q <= pwdata[LUM_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_LUM_THR) begin
			prdata = {{(32-LUM_W){1'b0}}, lum_thr_q};
		end
	end

endmodule

// ===== rtl/rcn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_front: first pipeline stage
// Sums the channels, applies the threshold and forms the three dividends.
// ----------------------------------------------------------------------------
module rcn_front
	import rcn_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [LANES-1:0][CHAN_W-1:0] chan,
	input  logic [LUM_W-1:0]             lum_thr,
	output logic                         out_valid,
	output rcn_div_t                     out_data
);

	logic             v_s1;
	rcn_div_t         d_s1;
	logic [LUM_W-1:0] lum;
	logic             pass;
	rcn_div_t         nxt;

	always_comb begin
		lum = LUM_W'(chan[0]) + LUM_W'(chan[1]) + LUM_W'(chan[2]);
		pass = lum > lum_thr;
		nxt.quo = '0;
		nxt.den = pass ? {lum, 1'b0} : DEN_W'(1);
		for (int i = 0; i < LANES; i++) begin
			nxt.rem[i] = pass ? NUM_W'(SCALE) * NUM_W'(chan[i]) + NUM_W'(lum) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;

endmodule

// ===== rtl/rcn_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_div_stage: one divider stage
// Restoring division over two quotient bits for all three channels.
// ----------------------------------------------------------------------------
module rcn_div_stage
	import rcn_pkg::*;
#(
	parameter int unsigned HI_BIT = QUO_W - 1
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  rcn_div_t in_data,
	output logic     out_valid,
	output rcn_div_t out_data
);

	logic             v_s;
	rcn_div_t         d_s;
	rcn_div_t         nxt;
	logic [CMP_W-1:0] r_w;
	logic [CMP_W-1:0] dsh;

	always_comb begin
		nxt = in_data;
		r_w = '0;
		dsh = '0;
		for (int l = 0; l < LANES; l++) begin
			for (int j = 0; j < BITS_PER_STAGE; j++) begin
				r_w = CMP_W'(nxt.rem[l]);
				dsh = CMP_W'(in_data.den) << (HI_BIT - j);
				if (r_w >= dsh) begin
					r_w = r_w - dsh;
					nxt.quo[l][HI_BIT - j] = 1'b1;
				end
				nxt.rem[l] = r_w[NUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= 1'b0;
		end else if (en) begin
			v_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s <= nxt;
		end
	end

	assign out_valid = v_s;
	assign out_data  = d_s;

endmodule

// ===== rtl/rgb_chromaticity_normalizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_chromaticity_normalizer_unit: normalised RGB chromaticity
// Scales each channel of a pixel to 255 times its share of the channel sum.
// ----------------------------------------------------------------------------
// One pixel word is taken per clock while the output word is not held, and it
// passes through one stage that forms the channel sum and the dividends, then
// four divider stages that resolve two quotient bits each. The whole pipeline
// stalls only while the output word waits. A pixel whose channel sum does not
// exceed the threshold register comes out black.
module rgb_chromaticity_normalizer_unit
	import rcn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,  // chan_a, chan_b, chan_c
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,  // norm_a, norm_b, norm_c
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic                         advance;
	logic [LUM_W-1:0]             lum_thr;
	logic [LANES-1:0][CHAN_W-1:0] chan;
	logic                         stg_valid [DIV_STAGES+1];
	rcn_div_t                     stg_data  [DIV_STAGES+1];
	rcn_div_t                     last;

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;
	assign chan     = s_tdata;

	rcn_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.lum_thr (lum_thr)
	);

	rcn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (s_tvalid),
		.chan      (chan),
		.lum_thr   (lum_thr),
		.out_valid (stg_valid[0]),
		.out_data  (stg_data[0])
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		rcn_div_stage #(
			.HI_BIT (QUO_W - 1 - BITS_PER_STAGE * k)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.in_valid  (stg_valid[k]),
			.in_data   (stg_data[k]),
			.out_valid (stg_valid[k+1]),
			.out_data  (stg_data[k+1])
		);
	end

	assign last     = stg_data[DIV_STAGES];
	assign m_tvalid = stg_valid[DIV_STAGES];
	assign m_tdata  = last.quo;

	// The quotient is complete only if every remainder ends below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (last.den != '0))
	else $error("divisor reached the output as zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (NUM_W'(last.rem[0]) < NUM_W'(last.den)) &&
			(NUM_W'(last.rem[1]) < NUM_W'(last.den)) &&
			(NUM_W'(last.rem[2]) < NUM_W'(last.den)))
	else $error("division remainder not below divisor");

	// Shares sum to 255; rounding each half up can add at most one.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (LUM_W'(m_tdata[7:0]) + LUM_W'(m_tdata[15:8]) +
			LUM_W'(m_tdata[23:16]) <= LUM_W'(256)))
	else $error("normalised channels sum above bound");

	assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == REG_LUM_THR) |=>
			(lum_thr == $past(pwdata[LUM_W-1:0])))
	else $error("threshold write not taken");

endmodule

// ===== tb/sv/rcn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_checker: result checker for the chromaticity normaliser
// Watches the pixel streams and the register port, keeps its own copy of the
// luminance threshold, predicts the normalised pixel for every word taken in
// and compares each word given out, lane by lane, with the oldest prediction.
// ----------------------------------------------------------------------------
module rcn_checker
	import rcn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [23:0]       s_tdata,  // chan_a, chan_b, chan_c
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [23:0]       m_tdata,  // norm_a, norm_b, norm_c
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending
);

	localparam logic [ADDR_W-1:0] THR_ADDR = {REG_LUM_THR, 2'b00};

	typedef struct packed {
		logic [CHAN_W-1:0] c;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] a;
	} pixel_t;

	logic [LUM_W-1:0] lum_limit;
	pixel_t           awaited_pixels[$];

	function automatic pixel_t chroma_of(input pixel_t pix, input logic [LUM_W-1:0] limit);
		int unsigned lum;
		pixel_t      res;
		lum = pix.a + pix.b + pix.c;
		res = '0;
		if (lum > limit) begin
			res.a = CHAN_W'((SCALE * pix.a + lum) / (2 * lum));
			res.b = CHAN_W'((SCALE * pix.b + lum) / (2 * lum));
			res.c = CHAN_W'((SCALE * pix.c + lum) / (2 * lum));
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		pixel_t got;
		pixel_t want;
		if (!arst_n) begin
			lum_limit = '0;
			awaited_pixels.delete();
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				awaited_pixels.push_back(chroma_of(pixel_t'(s_tdata), lum_limit));
			if (m_tvalid && m_tready) begin
				got = pixel_t'(m_tdata);
				if (awaited_pixels.size() == 0) begin
					report_mismatch("word with no pixel pending", m_tdata, 0);
				end else begin
					want = awaited_pixels.pop_front();
					if (got.a !== want.a)
						report_mismatch("norm_a", got.a, want.a);
					if (got.b !== want.b)
						report_mismatch("norm_b", got.b, want.b);
					if (got.c !== want.c)
						report_mismatch("norm_c", got.c, want.c);
				end
			end
			if (psel && penable && pready && paddr == THR_ADDR) begin
				if (pwrite)
					lum_limit = pwdata[LUM_W-1:0];
				else if (prdata !== 32'(lum_limit))
					report_mismatch("threshold read-back", prdata, lum_limit);
			end
			pending <= awaited_pixels.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the chromaticity normaliser
// Drives pixel words and threshold writes with random gaps on both streams,
// starting with hand-picked corner pixels and moving on to random pixels under
// a series of thresholds; the checker beside the block judges every word.
// ----------------------------------------------------------------------------
module tb_top;
	import rcn_pkg::*;

	localparam logic [ADDR_W-1:0] THR_ADDR    = {REG_LUM_THR, 2'b00};
	localparam logic [ADDR_W-1:0] NO_REG_ADDR = 3'd4;
	localparam int                PHASE_WORDS = 148;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [23:0]       s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [23:0]       m_tdata;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int                fail_count;
	int                pending;
	logic              calm;

	rgb_chromaticity_normalizer_unit dut (.*);

	rcn_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#1_600_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [23:0] pixel(input int unsigned a, input int unsigned b,
		input int unsigned c);
		return {CHAN_W'(c), CHAN_W'(b), CHAN_W'(a)};
	endfunction

	function automatic int unsigned draw_wait();
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic int unsigned edge_byte();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 1;
			2: return 254;
			default: return 255;
		endcase
	endfunction

	// Pixels with a sum close to the threshold are mixed in so that both sides
	// of the comparison are exercised under every setting below 765, the largest sum.
	function automatic logic [23:0] draw_pixel(input int unsigned limit);
		int unsigned kind;
		int unsigned total;
		int unsigned rest;
		int unsigned a;
		int unsigned b;
		int unsigned c;
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			a = $urandom_range(0, 255);
			b = $urandom_range(0, 255);
			c = $urandom_range(0, 255);
		end else if (kind < 8) begin
			total = (limit > 2) ? limit - 2 : 0;
			total = total + $urandom_range(0, 4);
			if (total > 765)
				total = 765;
			a = $urandom_range((total > 510) ? total - 510 : 0, (total > 255) ? 255 : total);
			rest = total - a;
			b = $urandom_range((rest > 255) ? rest - 255 : 0, (rest > 255) ? 255 : rest);
			c = rest - b;
		end else if (kind == 8) begin
			a = $urandom_range(0, 1);
			b = $urandom_range(0, 1);
			c = $urandom_range(0, 1);
			case ($urandom_range(0, 2))
				0: a = $urandom_range(0, 255);
				1: b = $urandom_range(0, 255);
				default: c = $urandom_range(0, 255);
			endcase
		end else begin
			a = edge_byte();
			b = edge_byte();
			c = edge_byte();
		end
		return pixel(a, b, c);
	endfunction

	task automatic push_pixel(input logic [23:0] pix);
		int unsigned gap;
		gap = draw_wait();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
		input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Bits above the register width are filled with noise, and a write to an
	// unused address must leave the threshold alone.
	task automatic set_threshold(input int unsigned limit);
		drain();
		apb_access(1'b1, THR_ADDR, {22'($urandom_range(0, 4_194_303)), LUM_W'(limit)});
		apb_access(1'b1, NO_REG_ADDR, $urandom());
		apb_access(1'b0, THR_ADDR, '0);
	endtask

	always begin
		int unsigned stall;
		stall = draw_wait();
		repeat (stall) begin
			@(negedge clk);
			m_tready <= 1'b0;
		end
		@(negedge clk);
		m_tready <= 1'b1;
		do @(posedge clk); while (!m_tvalid);
	end

	initial begin
		int unsigned limits[9];
		int unsigned limit;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		calm     = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_pixel(pixel(0, 0, 0));
		push_pixel(pixel(255, 255, 255));
		push_pixel(pixel(255, 0, 0));
		push_pixel(pixel(0, 255, 0));
		push_pixel(pixel(0, 0, 255));
		push_pixel(pixel(1, 0, 0));
		push_pixel(pixel(1, 1, 0));
		push_pixel(pixel(0, 1, 1));
		push_pixel(pixel(1, 1, 1));
		push_pixel(pixel(128, 127, 0));
		push_pixel(pixel(1, 254, 0));
		push_pixel(pixel(255, 254, 253));
		push_pixel(pixel(85, 170, 1));
		calm = 1'b0;
		set_threshold(764);
		push_pixel(pixel(255, 255, 255));
		push_pixel(pixel(255, 255, 254));
		push_pixel(pixel(254, 255, 254));
		set_threshold(765);
		push_pixel(pixel(255, 255, 255));
		set_threshold(1023);
		push_pixel(pixel(255, 255, 255));
		push_pixel(pixel(0, 0, 0));

		limits = '{0, 1023, 765, 766, 1, 382,
			$urandom_range(0, 765), $urandom_range(0, 765), $urandom_range(0, 1023)};
		foreach (limits[p]) begin
			limit = limits[p];
			set_threshold(limit);
			calm = ($urandom_range(0, 2) == 0);
			repeat (PHASE_WORDS) begin
				if ($urandom_range(0, 39) == 0)
					calm = !calm;
				if ($urandom_range(0, 99) == 0)
					drain();
				push_pixel(draw_pixel(limit));
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
